### rtl/core/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define ASSERT_CLK_ALL(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/api_dfr_pkg.sv
// Types and constants of the frame deframer.
package api_dfr_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_START_DELIM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN     = 1'b1;

    localparam logic [BYTE_W-1:0] START_DELIM_RST = 8'd126;
    localparam logic [LEN_W-1:0]  MAX_LEN_RST     = 16'd4096;
    localparam logic [BYTE_W-1:0] CSUM_BASE       = 8'hFF;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_BAD  = 2'd2,
        KIND_LEN  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  byte_index;
        logic [LEN_W-1:0]  frame_length;
        logic [BYTE_W-1:0] frame_type;
    } t_result;

endpackage

### rtl/core/api_dfr_parse.sv
// Frame parsing state machine: one received byte per accepted request.
module api_dfr_parse (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic [api_dfr_pkg::BYTE_W-1:0]   i_rx_byte,
    input  logic [api_dfr_pkg::BYTE_W-1:0]   i_start_delim,
    input  logic [api_dfr_pkg::LEN_W-1:0]    i_max_len,
    output logic                             o_res_valid,
    output api_dfr_pkg::t_result             o_res
);

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_DATA   = 3'd3,
        PH_CSUM   = 3'd4
    } t_phase;

    t_phase                           r_phase, n_phase;
    logic [api_dfr_pkg::LEN_W-1:0]    r_len, n_len;
    logic [api_dfr_pkg::LEN_W-1:0]    r_count, n_count;
    logic [api_dfr_pkg::BYTE_W-1:0]   r_sum, n_sum;
    logic [api_dfr_pkg::BYTE_W-1:0]   r_type, n_type;

    logic [api_dfr_pkg::LEN_W-1:0]    w_len_full;
    logic [api_dfr_pkg::LEN_W-1:0]    w_count_inc;
    logic [api_dfr_pkg::BYTE_W-1:0]   w_expect;

    assign w_len_full  = {r_len[api_dfr_pkg::LEN_W-1:api_dfr_pkg::BYTE_W], i_rx_byte};
    assign w_count_inc = r_count + 16'd1;
    assign w_expect    = api_dfr_pkg::CSUM_BASE - r_sum;

    always_comb begin
        n_phase     = r_phase;
        n_len       = r_len;
        n_count     = r_count;
        n_sum       = r_sum;
        n_type      = r_type;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_accept) begin
            case (r_phase)
                PH_LEN_HI: begin
                    n_len   = {i_rx_byte, 8'd0};
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_len = w_len_full;
                    if (w_len_full == '0 || w_len_full > i_max_len) begin
                        o_res_valid        = 1'b1;
                        o_res.kind         = api_dfr_pkg::KIND_LEN;
                        o_res.frame_length = w_len_full;
                        n_phase            = PH_HUNT;
                    end else begin
                        n_count = '0;
                        n_sum   = '0;
                        n_type  = '0;
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (r_count == '0) begin
                        n_type = i_rx_byte;
                    end
                    n_sum              = r_sum + i_rx_byte;
                    o_res_valid        = 1'b1;
                    o_res.kind         = api_dfr_pkg::KIND_DATA;
                    o_res.data_byte    = i_rx_byte;
                    o_res.byte_index   = r_count;
                    o_res.frame_length = r_len;
                    n_count            = w_count_inc;
                    if (w_count_inc >= r_len) begin
                        n_phase = PH_CSUM;
                    end
                end
                PH_CSUM: begin
                    o_res_valid        = 1'b1;
                    o_res.kind         = (w_expect == i_rx_byte) ? api_dfr_pkg::KIND_GOOD
                                                                 : api_dfr_pkg::KIND_BAD;
                    o_res.frame_length = r_len;
                    o_res.frame_type   = r_type;
                    n_phase            = PH_HUNT;
                end
                default: begin
                    n_phase = (i_rx_byte == i_start_delim) ? PH_LEN_HI : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_len   <= '0;
            r_count <= '0;
            r_sum   <= '0;
            r_type  <= '0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_type  <= n_type;
        end
    end

endmodule

### rtl/core/api_frame_deframer.sv
// Top level of the frame deframer: config registers, parser and output skid.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  rx in    | i_valid / o_stall   | i_rx_byte
//  result   | o_valid / i_stall   | o_kind o_data_byte o_byte_index
//           |                     | o_frame_length o_frame_type
//  config   | i_cfg_we            | i_cfg_idx i_cfg_data
//
// One byte request is taken per cycle while o_stall is low; its result (if any)
// is registered in the output register, or in the skid entry while the output is stalled.
// The parser state machine does all work for a byte combinationally.
// A two-entry output stage (output register plus skid) lets a byte be
// accepted while a result waits; o_stall rises only when both are full.
// Reset is synchronous, active low: parser goes to delimiter hunt, config
// registers take their defaults, both output entries are emptied.
module api_frame_deframer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // received byte requests
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [api_dfr_pkg::BYTE_W-1:0]       i_rx_byte,
    // result requests
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [1:0]                           o_kind,
    output logic [api_dfr_pkg::BYTE_W-1:0]       o_data_byte,
    output logic [api_dfr_pkg::LEN_W-1:0]        o_byte_index,
    output logic [api_dfr_pkg::LEN_W-1:0]        o_frame_length,
    output logic [api_dfr_pkg::BYTE_W-1:0]       o_frame_type,
    // configuration writes
    input  logic                                 i_cfg_we,
    input  logic [api_dfr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [api_dfr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // configuration
    logic [api_dfr_pkg::BYTE_W-1:0] r_start_delim;
    logic [api_dfr_pkg::LEN_W-1:0]  r_max_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_delim <= api_dfr_pkg::START_DELIM_RST;
            r_max_len     <= api_dfr_pkg::MAX_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                api_dfr_pkg::CFG_START_DELIM:
                    r_start_delim <= i_cfg_data[api_dfr_pkg::BYTE_W-1:0];
                api_dfr_pkg::CFG_MAX_LEN:
                    r_max_len <= i_cfg_data[api_dfr_pkg::LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // output stage: main register and skid entry
    logic                  r_out_valid;
    logic                  r_skid_valid;
    api_dfr_pkg::t_result  r_out;
    api_dfr_pkg::t_result  r_skid;

    logic                  w_in_accept;
    logic                  w_out_free;
    logic                  w_res_valid;
    api_dfr_pkg::t_result  w_res;

    // skid is only ever filled while a byte is accepted, so stall = skid full
    assign w_in_accept = i_valid && !r_skid_valid;
    assign w_out_free  = !r_out_valid || !i_stall;

    api_dfr_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_in_accept),
        .i_rx_byte     (i_rx_byte),
        .i_start_delim (r_start_delim),
        .i_max_len     (r_max_len),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            // skid full means no byte was accepted, so no new result competes
            r_out_valid  <= r_skid_valid || w_res_valid;
            r_skid_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end else if (w_res_valid) begin
            r_skid <= w_res;
        end
    end

    assign o_stall        = r_skid_valid;
    assign o_valid        = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_data_byte    = r_out.data_byte;
    assign o_byte_index   = r_out.byte_index;
    assign o_frame_length = r_out.frame_length;
    assign o_frame_type   = r_out.frame_type;

endmodule

### rtl/core/api_dfr_checker.sv
// Port-level checker for the frame deframer, bound to the top level.
`include "assert_macros.svh"

module api_dfr_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_valid,
    input logic                                 o_stall,
    input logic [api_dfr_pkg::BYTE_W-1:0]       i_rx_byte,
    input logic                                 o_valid,
    input logic                                 i_stall,
    input logic [1:0]                           o_kind,
    input logic [api_dfr_pkg::BYTE_W-1:0]       o_data_byte,
    input logic [api_dfr_pkg::LEN_W-1:0]        o_byte_index,
    input logic [api_dfr_pkg::LEN_W-1:0]        o_frame_length,
    input logic [api_dfr_pkg::BYTE_W-1:0]       o_frame_type
);

    // a stalled byte request holds
    `ASSERT_CLK(a_in_hold, i_clk, i_rst_n, (i_valid && o_stall) |=> (i_valid && $stable(i_rx_byte)), "stalled byte changed")

    // a stalled result holds
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_kind) && $stable(o_data_byte) && $stable(o_byte_index) && $stable(o_frame_length) && $stable(o_frame_type)), "stalled result changed")

    // only data results carry a byte and an index
    `ASSERT_CLK(a_nondata_zero, i_clk, i_rst_n, (o_valid && o_kind != api_dfr_pkg::KIND_DATA) |-> (o_data_byte == '0 && o_byte_index == '0), "non-data result has data fields")

    // a data index always lies inside the frame
    `ASSERT_CLK(a_index_range, i_clk, i_rst_n, (o_valid && o_kind == api_dfr_pkg::KIND_DATA) |-> (o_byte_index < o_frame_length), "data index beyond frame length")

    // reset empties the output stage
    `ASSERT_CLK_ALL(a_reset_empty, i_clk, (!i_rst_n) |=> (!o_valid && !o_stall), "output not empty after reset")

endmodule

bind api_frame_deframer api_dfr_checker u_api_dfr_checker (.*);

### test/tb.sv
// Self-checking bench for the frame deframer: byte stream in, parsed results checked.
`timescale 1ns / 1ps

module tb;
    import api_dfr_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTED = 10;

    // Parser phases of the bench's own copy of the deframer.
    typedef enum logic [2:0] {
        P_HUNT,
        P_LEN_HI,
        P_LEN_LO,
        P_DATA,
        P_CSUM
    } t_parse_phase;

    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  i_valid    = 1'b0;
    logic                  o_stall;
    logic [BYTE_W-1:0]     i_rx_byte  = '0;
    logic                  o_valid;
    logic                  i_stall    = 1'b0;
    logic [1:0]            o_kind;
    logic [BYTE_W-1:0]     o_data_byte;
    logic [LEN_W-1:0]      o_byte_index;
    logic [LEN_W-1:0]      o_frame_length;
    logic [BYTE_W-1:0]     o_frame_type;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    api_frame_deframer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_byte_index   (o_byte_index),
        .o_frame_length (o_frame_length),
        .o_frame_type   (o_frame_type),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    // ---------------------------------------------------------------------
    // Clock and reset: reset is applied once, at the start.
    // ---------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------------
    // Predictor state: register copies and parser state, at reset values.
    // ---------------------------------------------------------------------
    logic [BYTE_W-1:0] delim_cfg   = START_DELIM_RST;
    logic [LEN_W-1:0]  max_len_cfg = MAX_LEN_RST;
    t_parse_phase      ps_phase    = P_HUNT;
    logic [LEN_W-1:0]  ps_len      = '0;
    logic [LEN_W-1:0]  ps_count    = '0;
    logic [BYTE_W-1:0] ps_sum      = '0;
    logic [BYTE_W-1:0] ps_type     = '0;

    logic [BYTE_W-1:0] tx_bytes[$];         // bytes still to be sent
    t_result           pending_results[$];  // predicted results, oldest first
    t_result           next_result;
    t_result           want_r;

    int tx_idle_pct = 17;
    int rx_idle_pct = 55;
    int errors      = 0;
    int bytes_sent  = 0;
    int kind_seen[4];
    int cycle_cnt   = 0;

    // Stimulus plan: values the frame builder uses for the current setting.
    logic [BYTE_W-1:0] plan_delim = START_DELIM_RST;
    logic [LEN_W-1:0]  plan_max   = MAX_LEN_RST;

    // Advance the parser copy by one byte; returns 1 when a result is due.
    function automatic bit parse_byte(input logic [BYTE_W-1:0] b, output t_result r);
        logic [BYTE_W-1:0] want;
        r = '0;
        parse_byte = 1'b0;
        case (ps_phase)
            P_LEN_HI: begin
                ps_len   = {b, 8'h00};
                ps_phase = P_LEN_LO;
            end
            P_LEN_LO: begin
                ps_len = ps_len | {8'h00, b};
                if (ps_len == '0 || ps_len > max_len_cfg) begin
                    r.kind         = KIND_LEN;
                    r.frame_length = ps_len;
                    ps_phase       = P_HUNT;
                    parse_byte     = 1'b1;
                end else begin
                    ps_count = '0;
                    ps_sum   = '0;
                    ps_type  = '0;
                    ps_phase = P_DATA;
                end
            end
            P_DATA: begin
                if (ps_count == '0)
                    ps_type = b;
                ps_sum         = ps_sum + b;
                r.kind         = KIND_DATA;
                r.data_byte    = b;
                r.byte_index   = ps_count;
                r.frame_length = ps_len;
                ps_count       = ps_count + 1'b1;
                if (ps_count >= ps_len)
                    ps_phase = P_CSUM;
                parse_byte = 1'b1;
            end
            P_CSUM: begin
                want           = CSUM_BASE - ps_sum;
                r.kind         = (want == b) ? KIND_GOOD : KIND_BAD;
                r.frame_length = ps_len;
                r.frame_type   = ps_type;
                ps_phase       = P_HUNT;
                parse_byte     = 1'b1;
            end
            default: begin
                // hunting: anything but the delimiter is dropped
                if (b == delim_cfg)
                    ps_phase = P_LEN_HI;
            end
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Driver: presents bytes from tx_bytes, predicts at acceptance.
    // Register writes are mirrored here too, at the edge that takes them.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_START_DELIM)
                    delim_cfg = i_cfg_data[BYTE_W-1:0];
                else
                    max_len_cfg = i_cfg_data;
            end
            if (i_valid && !o_stall) begin
                if (parse_byte(i_rx_byte, next_result))
                    pending_results.push_back(next_result);
                void'(tx_bytes.pop_front());
                bytes_sent++;
            end
            // a stalled request holds its byte; otherwise decide afresh
            if (i_valid && o_stall) begin
                i_valid <= 1'b1;
            end else if (tx_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                i_valid   <= 1'b1;
                i_rx_byte <= tx_bytes[0];
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: every accepted result against the oldest prediction.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    if (errors < MAX_REPORTED)
                        $display("%0t: unexpected result kind=%0d data=%0d idx=%0d len=%0d type=%0d",
                                 $realtime, o_kind, o_data_byte, o_byte_index,
                                 o_frame_length, o_frame_type);
                    errors++;
                end else begin
                    want_r = pending_results.pop_front();
                    kind_seen[want_r.kind]++;
                    if (o_kind !== want_r.kind || o_data_byte !== want_r.data_byte ||
                        o_byte_index !== want_r.byte_index ||
                        o_frame_length !== want_r.frame_length ||
                        o_frame_type !== want_r.frame_type) begin
                        if (errors < MAX_REPORTED) begin
                            $display("%0t: mismatch exp kind=%0d data=%0d idx=%0d len=%0d type=%0d",
                                     $realtime, want_r.kind, want_r.data_byte,
                                     want_r.byte_index, want_r.frame_length,
                                     want_r.frame_type);
                            $display("%0t:          got kind=%0d data=%0d idx=%0d len=%0d type=%0d",
                                     $realtime, o_kind, o_data_byte, o_byte_index,
                                     o_frame_length, o_frame_type);
                        end
                        errors++;
                    end
                end
            end
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    // Wait until nothing is in flight, then wait on for the output stage.
    task automatic settle();
        while (tx_bytes.size() != 0 || i_valid || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Upper bits of the delimiter write are junk; only the low byte counts.
    task automatic configure(input logic [BYTE_W-1:0] delim, input logic [LEN_W-1:0] maxlen);
        logic [BYTE_W-1:0] junk;
        junk = $urandom_range(255);
        write_reg(CFG_START_DELIM, {junk, delim});
        write_reg(CFG_MAX_LEN, maxlen);
        plan_delim = delim;
        plan_max   = maxlen;
    endtask

    // Header, and with body: len random data bytes plus checksum.
    task automatic queue_frame(input logic [LEN_W-1:0] len, input bit body, input bit corrupt);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] d;
        sum = '0;
        tx_bytes.push_back(plan_delim);
        tx_bytes.push_back(len[15:8]);
        tx_bytes.push_back(len[7:0]);
        if (body) begin
            for (int k = 0; k < len; k++) begin
                d   = $urandom_range(255);
                sum = sum + d;
                tx_bytes.push_back(d);
            end
            d = CSUM_BASE - sum;
            if (corrupt)
                d = d ^ (8'h01 << $urandom_range(7));
            tx_bytes.push_back(d);
        end
    endtask

    // Mostly well-formed frames, plus rejects, noise and cut-off headers; only rejects at a zero maximum.
    task automatic queue_traffic(input int n);
        int stop;
        int pick;
        int lim;
        logic [LEN_W-1:0] len;
        stop = tx_bytes.size() + n;
        while (tx_bytes.size() < stop) begin
            pick = $urandom_range(99);
            if (plan_max == '0 || pick < 8) begin
                // length out of range: zero, or above the maximum
                if (plan_max == 16'hFFFF || $urandom_range(1) == 0)
                    len = '0;
                else
                    len = $urandom_range(16'hFFFF, plan_max + 1);
                queue_frame(len, 1'b0, 1'b0);
            end else if (pick < 18) begin
                repeat ($urandom_range(4, 1)) tx_bytes.push_back($urandom_range(255));
            end else if (pick < 21) begin
                // header cut short; the next frame's bytes land in it
                tx_bytes.push_back(plan_delim);
                tx_bytes.push_back($urandom_range(255));
            end else begin
                lim = (plan_max < 12) ? plan_max : 12;
                if ($urandom_range(99) < 3)
                    lim = (plan_max < 300) ? plan_max : 300;
                len = $urandom_range(lim, 1);
                queue_frame(len, 1'b1, pick < 30);
            end
        end
    endtask

    // Directed bytes at the reset setting (delimiter 0x7E, max 4096).
    logic [BYTE_W-1:0] directed [22] = '{
        8'h00, 8'hFF,                       // dropped while hunting
        8'h7E, 8'h00, 8'h01, 8'h7E, 8'h81,  // delimiter as data, good
        8'h7E, 8'h7E, 8'h00,                // delimiter as length byte, too long
        8'h7E, 8'h00, 8'h00,                // zero length
        8'h7E, 8'h10, 8'h01,                // one above the maximum
        8'h7E, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h55  // checksum mismatch
    };

    // ---------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------
    initial begin
        logic [BYTE_W-1:0] rnd_delim;
        while (!i_rst_n) @(posedge i_clk);

        // sender light idling, receiver heavy
        tx_idle_pct = 17;
        rx_idle_pct = 55;
        configure(START_DELIM_RST, MAX_LEN_RST);
        foreach (directed[k]) tx_bytes.push_back(directed[k]);
        queue_traffic(240);
        // leave the parser waiting for a length low byte across the next write
        tx_bytes.push_back(plan_delim);
        tx_bytes.push_back(8'h00);
        settle();

        configure(8'h00, 16'd1);
        queue_traffic(240);
        settle();

        // roles swapped
        tx_idle_pct = 55;
        rx_idle_pct = 17;
        configure(8'hFF, 16'hFFFF);
        queue_traffic(240);
        settle();

        rnd_delim = $urandom_range(255);
        configure(rnd_delim, $urandom_range(40, 1));
        queue_traffic(240);
        settle();

        // no idling; a zero maximum rejects every frame
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rnd_delim = $urandom_range(255);
        configure(rnd_delim, 16'd0);
        queue_traffic(120);
        settle();

        configure(8'h55, 16'd12);
        queue_traffic(360);
        settle();

        $display("Sent %0d bytes over six register settings, incl. delimiter and length extremes.",
                 bytes_sent);
        $display("Checked %0d data bytes, %0d good, %0d bad checksum, %0d length rejects.",
                 kind_seen[KIND_DATA], kind_seen[KIND_GOOD], kind_seen[KIND_BAD],
                 kind_seen[KIND_LEN]);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/api_dfr_pkg.sv
rtl/core/api_dfr_parse.sv
rtl/core/api_frame_deframer.sv
rtl/core/api_dfr_checker.sv
test/tb.sv
